// ----- design/dashed_line_splitter_defines.svh -----
// ----------------------------------------------------------------------------
// dashed_line_splitter_defines
// Assertion macros used by the dashed line splitter sequencer (dls_ctrl).
// ----------------------------------------------------------------------------
`ifndef DASHED_LINE_SPLITTER_DEFINES_SVH
`define DASHED_LINE_SPLITTER_DEFINES_SVH

// same-cycle implication
`define DLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dls_pkg.sv -----
// ----------------------------------------------------------------------------
// dls_pkg
// Types and constants of the dashed line splitter.
// ----------------------------------------------------------------------------
package dls_pkg;

    localparam int unsigned CfgW    = 24;
    localparam int unsigned SqrtIter = 35;   // result bits of the square root
    localparam int unsigned DivIter  = 30;   // quotient bits below the leading one

    localparam logic [CfgW-1:0] DASH_RESET = 24'd131072;  // 2.0
    localparam logic [CfgW-1:0] GAP_RESET  = 24'd81920;   // 1.25

    localparam logic [2:0] ADDR_DASH = 3'd0;
    localparam logic [2:0] ADDR_GAP  = 3'd4;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic               dashed;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] piece_start_x;
        logic signed [31:0] piece_start_y;
        logic signed [31:0] piece_start_z;
        logic signed [31:0] piece_end_x;
        logic signed [31:0] piece_end_y;
        logic signed [31:0] piece_end_z;
        logic               last_piece;
        logic               truncated;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_RINIT,
        ST_SQRT,
        ST_CHK,
        ST_DIVI,
        ST_DIV,
        ST_DST,
        ST_MUL,
        ST_ADD,
        ST_EMIT,
        ST_PASS
    } state_t;

    typedef struct packed {
        logic       load_in;
        logic       sq_acc;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic       dash_init;
        logic       mul;
        logic       add;
        logic       dash_adv;
        logic       out_load;
        logic       pass;
        logic       last;
        logic       trunc;
        logic [1:0] comp;
        logic       sel_end;
        logic [2:0] pt;
    } cmd_t;

    typedef struct packed {
        logic len_zero;
        logic more;
        logic out_free;
    } status_t;

endpackage

// ----- design/dashed_line_splitter.sv -----
// ----------------------------------------------------------------------------
// dashed_line_splitter
// Cuts a dashed 3-D Q16.16 segment into dashes of dash_length spaced by gap_length; a plain one passes as one beat.
// ----------------------------------------------------------------------------
//  channel  | signals                         | beat
//  ---------+---------------------------------+------------------------------
//  in       | in_valid, in_stall, in_beat     | one segment + dashed flag
//  out      | out_valid, out_stall, out_beat  | one piece, last/truncated
//  cfg      | APB psel..prdata                | dash_length @0, gap_length @4
//
//  Plain segment: passed through as its single beat.
//  Dashed segment: three squares, the bit-serial root, three divides on the
//  shared restoring divider, then per dash six multiply/add pairs on one
//  multiplier and an emit.
//  Reset clears control and restores dash 2.0 and gap 1.25.
//  One segment in flight; a stalled out beat holds the sequencer in emit or pass.
// ----------------------------------------------------------------------------
module dashed_line_splitter #(
    parameter int unsigned MAX_DASHES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dls_pkg::in_beat_t   in_beat,
    output logic                out_valid,
    input  logic                out_stall,
    output dls_pkg::out_beat_t  out_beat,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import dls_pkg::*;

    logic [CfgW-1:0] dash_reg;
    logic [CfgW-1:0] gap_reg;
    logic            wr_en;
    cmd_t            cmd;
    status_t         st;

    // config writes land on the access cycle; pready is tied high
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_reg <= DASH_RESET;
            gap_reg  <= GAP_RESET;
        end
        else if (wr_en)
        begin
            case (paddr)
                ADDR_DASH: dash_reg <= pwdata[CfgW-1:0];
                ADDR_GAP:  gap_reg  <= pwdata[CfgW-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_DASH: prdata = {8'd0, dash_reg};
            ADDR_GAP:  prdata = {8'd0, gap_reg};
            default:   prdata = '0;
        endcase
    end

    // sequencer: one command word per cycle into the datapath
    dls_ctrl #(
        .MAX_DASHES (MAX_DASHES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_dashed (in_beat.dashed),
        .in_stall  (in_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // arithmetic and the output beat register
    dls_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_beat     (in_beat),
        .dash_length (dash_reg),
        .gap_length  (gap_reg),
        .cmd         (cmd),
        .st          (st),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_beat    (out_beat)
    );

endmodule

// ----- design/dls_datapath.sv -----
// ----------------------------------------------------------------------------
// dls_datapath
// Squares, bit-serial root and divider, point multiplier, output register.
// ----------------------------------------------------------------------------
module dls_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dls_pkg::in_beat_t      in_beat,
    input  logic [23:0]            dash_length,
    input  logic [23:0]            gap_length,
    input  dls_pkg::cmd_t          cmd,
    output dls_pkg::status_t       st,
    output logic                   out_valid,
    input  logic                   out_stall,
    output dls_pkg::out_beat_t     out_beat
);
    import dls_pkg::*;

    logic [31:0]  s_in [3];
    logic [31:0]  e_in [3];
    logic [31:0]  start_reg [3];
    logic [31:0]  end_reg [3];
    logic [31:0]  abs_reg [3];
    logic         neg_reg [3];
    logic [30:0]  mag_reg [3];
    logic [31:0]  pts_reg [6];
    logic [65:0]  sum_reg;
    logic [69:0]  rad_reg;
    logic [36:0]  rem_reg;
    logic [34:0]  root_reg;
    logic [34:0]  drem_reg;
    logic [30:0]  quo_reg;
    logic [35:0]  off_reg;
    logic [65:0]  prod_reg;
    logic         out_valid_reg;
    out_beat_t    out_beat_reg;

    logic [63:0]  sq_prod;
    logic [38:0]  rem_sh;
    logic [38:0]  trial;
    logic [34:0]  a35;
    logic         a_ge;
    logic [35:0]  r2;
    logic         r2_ge;
    logic [24:0]  step25;
    logic [35:0]  off_step;
    logic [35:0]  end_off;
    logic [34:0]  de;
    logic [34:0]  pos;
    logic [31:0]  m;
    logic [31:0]  point;
    logic         out_free;

    assign s_in[0] = in_beat.start_x;
    assign s_in[1] = in_beat.start_y;
    assign s_in[2] = in_beat.start_z;
    assign e_in[0] = in_beat.end_x;
    assign e_in[1] = in_beat.end_y;
    assign e_in[2] = in_beat.end_z;

    assign sq_prod  = abs_reg[cmd.comp] * abs_reg[cmd.comp];
    assign rem_sh   = {rem_reg, rad_reg[69:68]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign a35      = {3'b000, abs_reg[cmd.comp]};
    assign a_ge     = a35 >= root_reg;
    assign r2       = {drem_reg, 1'b0};
    assign r2_ge    = r2 >= {1'b0, root_reg};
    assign step25   = {1'b0, dash_length} + {1'b0, gap_length};
    assign off_step = off_reg + {11'd0, step25};
    assign end_off  = off_reg + {12'd0, dash_length};
    assign de       = (end_off < {1'b0, root_reg}) ? end_off[34:0] : root_reg;
    assign pos      = cmd.sel_end ? de : off_reg[34:0];
    assign m        = prod_reg[61:30];
    assign point    = neg_reg[cmd.comp] ? start_reg[cmd.comp] - m
                                        : start_reg[cmd.comp] + m;
    assign out_free = !out_valid_reg || !out_stall;

    assign st.len_zero = (root_reg == '0);
    assign st.more     = off_step < {1'b0, root_reg};
    assign st.out_free = out_free;

    always_ff @(posedge clk)
    begin
        logic signed [32:0] dl;
        for (int c = 0; c < 3; c++)
        begin
            if (cmd.load_in)
            begin
                dl = $signed({e_in[c][31], e_in[c]}) - $signed({s_in[c][31], s_in[c]});
                start_reg[c] <= s_in[c];
                end_reg[c]   <= e_in[c];
                neg_reg[c]   <= dl[32];
                abs_reg[c]   <= dl[32] ? 32'(-dl) : dl[31:0];
            end
        end
        if (cmd.load_in)
            sum_reg <= '0;
        else if (cmd.sq_acc)
            sum_reg <= sum_reg + {2'b00, sq_prod};

        if (cmd.sqrt_init)
        begin
            rad_reg  <= {4'b0000, sum_reg};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[67:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= 37'(rem_sh - trial);
                root_reg <= {root_reg[33:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[36:0];
                root_reg <= {root_reg[33:0], 1'b0};
            end
        end

        if (cmd.div_init)
        begin
            drem_reg <= a_ge ? a35 - root_reg : a35;
            quo_reg  <= {30'd0, a_ge};
        end
        else if (cmd.div_step)
        begin
            drem_reg <= r2_ge ? 35'(r2 - {1'b0, root_reg}) : r2[34:0];
            quo_reg  <= {quo_reg[29:0], r2_ge};
        end
        if (cmd.div_store)
            mag_reg[cmd.comp] <= quo_reg;

        if (cmd.dash_init)
            off_reg <= '0;
        else if (cmd.dash_adv)
            off_reg <= off_step;

        if (cmd.mul)
            prod_reg <= mag_reg[cmd.comp] * pos;
        if (cmd.add)
            pts_reg[cmd.pt] <= point;

        if (cmd.out_load)
        begin
            if (cmd.pass)
            begin
                out_beat_reg.piece_start_x <= start_reg[0];
                out_beat_reg.piece_start_y <= start_reg[1];
                out_beat_reg.piece_start_z <= start_reg[2];
                out_beat_reg.piece_end_x   <= end_reg[0];
                out_beat_reg.piece_end_y   <= end_reg[1];
                out_beat_reg.piece_end_z   <= end_reg[2];
            end
            else
            begin
                out_beat_reg.piece_start_x <= pts_reg[0];
                out_beat_reg.piece_start_y <= pts_reg[1];
                out_beat_reg.piece_start_z <= pts_reg[2];
                out_beat_reg.piece_end_x   <= pts_reg[3];
                out_beat_reg.piece_end_y   <= pts_reg[4];
                out_beat_reg.piece_end_z   <= pts_reg[5];
            end
            out_beat_reg.last_piece <= cmd.last;
            out_beat_reg.truncated  <= cmd.trunc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

endmodule

// ----- design/dls_ctrl.sv -----
// ----------------------------------------------------------------------------
// dls_ctrl
// Sequencer: squares, root, three divides, then six points per dash; plain segments pass through.
// ----------------------------------------------------------------------------
module dls_ctrl #(
    parameter int unsigned MAX_DASHES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_dashed,
    output logic               in_stall,
    input  dls_pkg::status_t   st,
    output dls_pkg::cmd_t      cmd
);
    import dls_pkg::*;

    localparam int unsigned NW = $clog2(MAX_DASHES + 1);

    state_t        state_reg, state_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [1:0]    comp_reg, comp_next;
    logic [2:0]    pt_reg, pt_next;
    logic [NW-1:0] n_reg, n_next;
    logic          cap;

    assign cap      = (n_reg + 1'b1) >= NW'(MAX_DASHES);
    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            pt_reg    <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            pt_reg    <= pt_next;
            n_reg     <= n_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        pt_next    = pt_reg;
        n_next     = n_reg;
        cmd        = '0;
        cmd.comp   = comp_reg;
        cmd.pt     = pt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    comp_next   = '0;
                    state_next  = in_dashed ? ST_SQ : ST_PASS;
                end
            end
            ST_SQ:
            begin
                cmd.sq_acc = 1'b1;
                comp_next  = comp_reg + 2'd1;
                if (comp_reg == 2'd2)
                    state_next = ST_RINIT;
            end
            ST_RINIT:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'(SqrtIter - 1))
                    state_next = ST_CHK;
            end
            ST_CHK:
            begin
                comp_next  = '0;
                state_next = st.len_zero ? ST_IDLE : ST_DIVI;
            end
            ST_DIVI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DivIter - 1))
                    state_next = ST_DST;
            end
            ST_DST:
            begin
                cmd.div_store = 1'b1;
                if (comp_reg == 2'd2)
                begin
                    cmd.dash_init = 1'b1;
                    pt_next       = '0;
                    n_next        = '0;
                    comp_next     = '0;
                    state_next    = ST_MUL;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_DIVI;
                end
            end
            ST_MUL:
            begin
                cmd.mul     = 1'b1;
                cmd.sel_end = (pt_reg >= 3'd3);
                state_next  = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add = 1'b1;
                if (pt_reg == 3'd5)
                    state_next = ST_EMIT;
                else
                begin
                    pt_next    = pt_reg + 3'd1;
                    comp_next  = (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.dash_adv = 1'b1;
                    cmd.last     = !st.more || cap;
                    cmd.trunc    = st.more && cap;
                    n_next       = n_reg + 1'b1;
                    pt_next      = '0;
                    comp_next    = '0;
                    state_next   = (!st.more || cap) ? ST_IDLE : ST_MUL;
                end
            end
            ST_PASS:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.pass     = 1'b1;
                    cmd.last     = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`include "dashed_line_splitter_defines.svh"

    `DLS_ASSERT_NOW(a_load_free, cmd.out_load, st.out_free, "result loaded over a waiting beat")
    `DLS_ASSERT_NOW(a_n_cap, 1'b1, n_reg <= NW'(MAX_DASHES), "dash count past cap")
    `DLS_ASSERT_NEXT(a_zero_len, (state_reg == ST_CHK) && st.len_zero, state_reg == ST_IDLE, "zero length not dropped")
    `DLS_ASSERT_NOW(a_trunc_last, cmd.trunc, cmd.last && cmd.out_load, "truncated on non-final beat")

endmodule
